// ===== hw/rtl/lbci_pkg.sv =====
// Shared types, codes and constants for the log-structured cache index.
package lbci_pkg;

    // Default sizes of the index.
    localparam int unsigned TABLE_ENTRIES = 256;
    localparam int unsigned TAG_COUNT     = 4;

    // Tag value that matches anything in a delete.
    localparam logic [15:0] TAG_WILDCARD = 16'hFFFF;

    // Configuration register reset values.
    localparam logic [31:0] BLOCK_BYTES_RESET = 32'd67108864;
    localparam logic [15:0] BLOCK_LIMIT_RESET = 16'd16;

    // Configuration register indexes.
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_BLOCK_LIMIT = 1'b1;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_TOO_BIG    = 2'd3
    } status_t;

    // One stored table entry.
    typedef struct packed {
        logic [63:0] tags;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] block;
        logic [31:0] item;
        logic [31:0] dir;
    } entry_t;

    // One incoming request.
    typedef struct packed {
        op_t         op;
        logic [31:0] dir;
        logic [31:0] item;
        logic [31:0] bytes;
        logic [63:0] tags;
    } request_t;

    // One result.
    typedef struct packed {
        status_t     status;
        logic [31:0] block;
        logic [31:0] pos;
        logic [31:0] bytes;
        logic [63:0] tags;
        logic [8:0]  count;
    } result_t;

endpackage

// ===== hw/rtl/lbci_mem.sv =====
// Entry store: one write port and one registered read port.
module lbci_mem #(
    parameter int unsigned DEPTH = lbci_pkg::TABLE_ENTRIES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  lbci_pkg::entry_t         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output lbci_pkg::entry_t         rdata
);

    lbci_pkg::entry_t mem [DEPTH];
    lbci_pkg::entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lbci_ctrl.sv =====
// Sequencer that scans, evicts and writes the entry store one entry a cycle.
module lbci_ctrl #(
    parameter int unsigned TABLE_ENTRIES = lbci_pkg::TABLE_ENTRIES,
    parameter int unsigned TAG_COUNT     = lbci_pkg::TAG_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lbci_pkg::request_t               req,
    input  logic [31:0]                      block_bytes,
    input  logic [15:0]                      block_limit,
    output logic [$clog2(TABLE_ENTRIES)-1:0] mem_raddr,
    input  lbci_pkg::entry_t                 mem_rdata,
    output logic                             mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] mem_waddr,
    output lbci_pkg::entry_t                 mem_wdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output lbci_pkg::result_t                res
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = IW + 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVICT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg,      state_next;
    lbci_pkg::request_t  req_reg,        req_next;
    logic [CW-1:0]       cnt_reg,        cnt_next;
    logic                pv_reg,         pv_next;
    logic [IW-1:0]       pidx_reg,       pidx_next;
    logic                hit_found_reg,  hit_found_next;
    logic [IW-1:0]       hit_idx_reg,    hit_idx_next;
    lbci_pkg::entry_t    hit_rec_reg,    hit_rec_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg,   free_idx_next;
    logic [8:0]          count_reg,      count_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]         fill_reg,       fill_next;
    logic [31:0]         newest_reg,     newest_next;
    logic [31:0]         oldest_reg,     oldest_next;
    logic [15:0]         live_reg,       live_next;
    lbci_pkg::result_t   res_reg,        res_next;

    logic [63:0] tag_mask;
    logic        rd_valid;
    logic        key_eq;
    logic        tag_eq;
    logic        del_hit;
    logic        evict_hit;
    logic        need_open;
    logic        need_evict;
    logic        scan_end;
    logic [IW-1:0] write_idx;

    // Tags past the configured count are stored as zero and never compared.
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            tag_mask[16*t +: 16] = (t < TAG_COUNT) ? 16'hFFFF : 16'h0000;
        end
    end

    // Match terms for the entry whose read data is present this cycle.
    always_comb
    begin
        rd_valid = valid_reg[pidx_reg];
        key_eq   = rd_valid && (mem_rdata.dir == req_reg.dir)
                   && (mem_rdata.item == req_reg.item);
        tag_eq   = 1'b1;
        for (int t = 0; t < 4; t++)
        begin
            if (t < TAG_COUNT)
            begin
                if ((req_reg.tags[16*t +: 16] != lbci_pkg::TAG_WILDCARD)
                    && (req_reg.tags[16*t +: 16] != mem_rdata.tags[16*t +: 16]))
                begin
                    tag_eq = 1'b0;
                end
            end
        end
        if (req_reg.dir == 32'd0)
        begin
            del_hit = rd_valid;
        end
        else if (mem_rdata.dir != req_reg.dir)
        begin
            del_hit = 1'b0;
        end
        else if (req_reg.item != 32'd0)
        begin
            del_hit = rd_valid && (mem_rdata.item == req_reg.item);
        end
        else
        begin
            del_hit = rd_valid && tag_eq;
        end
        evict_hit  = rd_valid && (mem_rdata.block == oldest_reg);
        need_open  = (live_reg == 16'd0)
                     || (({1'b0, req_reg.bytes} + {1'b0, fill_reg}) > {1'b0, block_bytes});
        need_evict = (live_reg != 16'd0) && (live_reg >= block_limit);
        scan_end   = (cnt_reg == LAST_CNT) && !pv_reg;
        write_idx  = hit_found_reg ? hit_idx_reg : free_idx_reg;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        logic [15:0] live_v;
        logic [31:0] old_v;

        state_next      = state_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        live_next       = live_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = write_idx;
        mem_wdata       = '0;
        mem_raddr       = cnt_reg[IW-1:0];
        live_v          = live_reg;
        old_v           = oldest_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req;
                    req_next.tags = req.tags & tag_mask;
                    res_next      = '0;
                    cnt_next        = '0;
                    pv_next         = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    count_next      = '0;
                    if (req.op == lbci_pkg::OP_NOP)
                    begin
                        state_next = S_DONE;
                    end
                    else if ((req.op == lbci_pkg::OP_ADD) && (req.bytes > block_bytes))
                    begin
                        res_next.status = lbci_pkg::ST_TOO_BIG;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN, S_EVICT:
            begin
                // Issue one read a cycle.
                if (cnt_reg != LAST_CNT)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end

                // Handle the entry that was read last cycle.
                if (pv_reg)
                begin
                    if (state_reg == S_SCAN)
                    begin
                        if (req_reg.op == lbci_pkg::OP_DEL)
                        begin
                            if (del_hit)
                            begin
                                valid_next[pidx_reg] = 1'b0;
                                if (count_reg != 9'h1FF)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (key_eq && !hit_found_reg)
                            begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = pidx_reg;
                                hit_rec_next   = mem_rdata;
                            end
                            if (!rd_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = pidx_reg;
                            end
                        end
                    end
                    else
                    begin
                        if (evict_hit)
                        begin
                            valid_next[pidx_reg] = 1'b0;
                            if (hit_found_reg && (hit_idx_reg == pidx_reg))
                            begin
                                hit_found_next = 1'b0;
                            end
                        end
                        if ((!rd_valid || evict_hit) && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = pidx_reg;
                        end
                    end
                end

                // End of a pass over the table.
                if (scan_end)
                begin
                    if (state_reg == S_EVICT)
                    begin
                        live_v = live_reg - 1'b1;
                        old_v  = oldest_reg + 1'b1;
                    end
                    if ((state_reg == S_SCAN) && (req_reg.op == lbci_pkg::OP_DEL))
                    begin
                        res_next.status = lbci_pkg::ST_OK;
                        res_next.count  = count_reg;
                        state_next      = S_DONE;
                    end
                    else if ((state_reg == S_SCAN) && (req_reg.op == lbci_pkg::OP_GET))
                    begin
                        if (hit_found_reg)
                        begin
                            res_next.status = lbci_pkg::ST_OK;
                            res_next.block  = hit_rec_reg.block;
                            res_next.pos    = hit_rec_reg.offset;
                            res_next.bytes  = hit_rec_reg.size;
                            res_next.tags   = hit_rec_reg.tags;
                        end
                        else
                        begin
                            res_next.status = lbci_pkg::ST_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                    else if ((state_reg == S_SCAN) && !hit_found_reg && !free_found_reg)
                    begin
                        res_next.status = lbci_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else if ((state_reg == S_SCAN) && need_open && need_evict)
                    begin
                        cnt_next        = '0;
                        pv_next         = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_EVICT;
                    end
                    else
                    begin
                        // Open a new block where needed, then store.
                        if ((state_reg == S_EVICT) || need_open)
                        begin
                            fill_next = '0;
                            if (live_v != 16'd0)
                            begin
                                newest_next = newest_reg + 1'b1;
                                oldest_next = old_v;
                            end
                            else
                            begin
                                oldest_next = newest_reg;
                            end
                            live_next = live_v + 1'b1;
                        end
                        state_next = S_WRITE;
                    end
                end
            end

            S_WRITE:
            begin
                mem_we           = 1'b1;
                mem_wdata.dir    = req_reg.dir;
                mem_wdata.item   = req_reg.item;
                mem_wdata.block  = newest_reg;
                mem_wdata.offset = fill_reg;
                mem_wdata.size   = req_reg.bytes;
                mem_wdata.tags   = req_reg.tags;
                valid_next[write_idx] = 1'b1;
                fill_next        = fill_reg + req_reg.bytes;
                res_next.status  = lbci_pkg::ST_OK;
                res_next.block   = newest_reg;
                res_next.pos     = fill_reg;
                res_next.bytes   = req_reg.bytes;
                res_next.tags    = req_reg.tags;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            valid_reg  <= '0;
            fill_reg   <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            live_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            valid_reg  <= valid_next;
            fill_reg   <= fill_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            live_reg   <= live_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pidx_reg       <= pidx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rec_reg    <= hit_rec_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        count_reg      <= count_next;
        res_reg        <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== hw/rtl/log_block_cache_index.sv =====
// Throughput: one request at a time, accepted from the cycle after the previous result is handed to the
// output register; the one-entry-per-cycle scan of the entry store sets the pace.
// Reset clears all valid bits at once, the block counters and the configuration registers;
// the entry store itself is not cleared and needs no clearing pass.
module log_block_cache_index #(
    parameter int unsigned TABLE_ENTRIES = lbci_pkg::TABLE_ENTRIES,
    parameter int unsigned TAG_COUNT     = lbci_pkg::TAG_COUNT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dir_key, item_key, item_bytes, tag_a, tag_b, tag_c, tag_d
    input  logic [159:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_number, byte_position, found_bytes, found_tag_a..d, deleted_count, zero pad
    output logic [175:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);

    logic [31:0]        block_bytes_reg;
    logic [15:0]        block_limit_reg;
    logic               out_valid_reg;
    lbci_pkg::result_t  out_reg;
    lbci_pkg::request_t req;
    lbci_pkg::result_t  res;
    lbci_pkg::entry_t   mem_rdata;
    lbci_pkg::entry_t   mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [IW-1:0]      mem_waddr;
    logic               mem_we;
    logic               res_valid;
    logic               res_ready;

    // Unpack the incoming request.
    always_comb
    begin
        req.op    = lbci_pkg::op_t'(s_tuser);
        req.dir   = s_tdata[31:0];
        req.item  = s_tdata[63:32];
        req.bytes = s_tdata[95:64];
        req.tags  = s_tdata[159:96];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= lbci_pkg::BLOCK_BYTES_RESET;
            block_limit_reg <= lbci_pkg::BLOCK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lbci_pkg::REG_BLOCK_BYTES)
            begin
                block_bytes_reg <= cfg_data;
            end
            else
            begin
                block_limit_reg <= cfg_data[15:0];
            end
        end
    end

    lbci_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lbci_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAG_COUNT     (TAG_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req         (req),
        .block_bytes (block_bytes_reg),
        .block_limit (block_limit_reg),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register between the sequencer and the result channel.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.count, out_reg.tags, out_reg.bytes,
                       out_reg.pos, out_reg.block};

endmodule
